// ===== src/x86_string_instruction_step_core_assert.svh =====
// Assertion macros shared by the checker.
`ifndef X86_STRING_INSTRUCTION_STEP_CORE_ASSERT_SVH
`define X86_STRING_INSTRUCTION_STEP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define X86STR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x86str: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define X86STR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("x86str: assertion failed");

`endif

// ===== src/x86str_pkg.sv =====
`default_nettype none

package x86str_pkg;

    typedef enum logic [2:0] {
        OP_MOVS = 3'd0,
        OP_CMPS = 3'd1,
        OP_SCAS = 3'd2,
        OP_STOS = 3'd3,
        OP_LODS = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_WORD  = 2'd1,
        SZ_DWORD = 2'd2
    } elem_size_t;

    localparam logic [2:0] SEG_DS  = 3'd3;
    localparam logic [2:0] SEG_MAX = 3'd5;

    // Step an index; with 16-bit addressing only the low half moves and wraps.
    function automatic logic [31:0] step_index(input logic [31:0] idx,
                                               input logic [31:0] delta,
                                               input logic down,
                                               input logic a32);
        logic [31:0] n;
        n = down ? (idx - delta) : (idx + delta);
        return a32 ? n : {idx[31:16], n[15:0]};
    endfunction

    // OSZAPC of a - b at the width given by mask/top.
    function automatic logic [5:0] sub_flags(input logic [31:0] a_in,
                                             input logic [31:0] b_in,
                                             input logic [31:0] mask,
                                             input logic [31:0] top);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [5:0]  f;
        a    = a_in & mask;
        b    = b_in & mask;
        r    = (a - b) & mask;
        f[5] = (((a ^ b) & (a ^ r)) & top) != 32'd0;
        f[4] = (r & top) != 32'd0;
        f[3] = (r == 32'd0);
        f[2] = a[4] ^ b[4] ^ r[4];
        f[1] = ~^r[7:0];
        f[0] = (a < b);
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/x86_string_instruction_step_core.sv =====
// From an input transfer, a step passes through the input register, then
// the result register, before its result is offered.
// Throughput: one string instruction step per cycle, sustained while out_stall is low.
// An input register and a result register hold one item each; the input
// side keeps taking items while a result waits, until both are occupied.
// Reset (rst_n low, asynchronous) empties both registers; data is not cleared.
`default_nettype none

module x86_string_instruction_step_core
    import x86str_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [1:0]  elem_size,
    input  wire logic        addr_32,
    input  wire logic        dir_down,
    input  wire logic [2:0]  seg_override,
    input  wire logic [31:0] src_index,
    input  wire logic [31:0] dst_index,
    input  wire logic [31:0] accumulator,
    input  wire logic [31:0] src_data,
    input  wire logic [31:0] dst_data,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic [31:0] next_src_index,
    output      logic [31:0] next_dst_index,
    output      logic [2:0]  src_segment,
    output      logic        store_enable,
    output      logic [31:0] store_data,
    output      logic [31:0] acc_result,
    output      logic        flags_write,
    output      logic [5:0]  flags_out
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        advance;
    logic        load;

    logic [2:0]  opcode_reg;
    logic [1:0]  elem_size_reg;
    logic        addr_32_reg;
    logic        dir_down_reg;
    logic [2:0]  seg_override_reg;
    logic [31:0] src_index_reg;
    logic [31:0] dst_index_reg;
    logic [31:0] accumulator_reg;
    logic [31:0] src_data_reg;
    logic [31:0] dst_data_reg;

    logic [31:0] nsi_next;
    logic [31:0] ndi_next;
    logic [2:0]  seg_next;
    logic        st_en_next;
    logic [31:0] st_data_next;
    logic [31:0] acc_next;
    logic        fl_en_next;
    logic [5:0]  flags_next;

    logic [31:0] nsi_reg;
    logic [31:0] ndi_reg;
    logic [2:0]  seg_reg;
    logic        st_en_reg;
    logic [31:0] st_data_reg;
    logic [31:0] acc_reg;
    logic        fl_en_reg;
    logic [5:0]  flags_reg;

    logic [31:0] mask;
    logic [31:0] top;
    logic [31:0] delta;
    logic [31:0] si_step;
    logic [31:0] di_step;

    // Handshake: result register frees when empty or its transfer completes
    assign out_free       = !out_valid_reg || !out_stall;
    assign advance        = in_valid_reg && out_free;
    assign in_stall       = in_valid_reg && !out_free;
    assign load           = in_valid && !in_stall;
    assign in_valid_next  = load || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            opcode_reg       <= opcode;
            elem_size_reg    <= elem_size;
            addr_32_reg      <= addr_32;
            dir_down_reg     <= dir_down;
            seg_override_reg <= seg_override;
            src_index_reg    <= src_index;
            dst_index_reg    <= dst_index;
            accumulator_reg  <= accumulator;
            src_data_reg     <= src_data;
            dst_data_reg     <= dst_data;
        end
    end

    // Element width; size code 3 behaves as dword
    always_comb
    begin
        case (elem_size_reg)
            SZ_BYTE:
            begin
                mask  = 32'h0000_00FF;
                top   = 32'h0000_0080;
                delta = 32'd1;
            end
            SZ_WORD:
            begin
                mask  = 32'h0000_FFFF;
                top   = 32'h0000_8000;
                delta = 32'd2;
            end
            default:
            begin
                mask  = 32'hFFFF_FFFF;
                top   = 32'h8000_0000;
                delta = 32'd4;
            end
        endcase
    end

    assign si_step  = step_index(src_index_reg, delta, dir_down_reg, addr_32_reg);
    assign di_step  = step_index(dst_index_reg, delta, dir_down_reg, addr_32_reg);
    assign seg_next = (seg_override_reg > SEG_MAX) ? SEG_DS : seg_override_reg;

    always_comb
    begin
        nsi_next     = src_index_reg;
        ndi_next     = dst_index_reg;
        st_en_next   = 1'b0;
        st_data_next = 32'd0;
        acc_next     = accumulator_reg;
        fl_en_next   = 1'b0;
        flags_next   = 6'd0;
        case (opcode_reg)
            OP_MOVS:
            begin
                st_en_next   = 1'b1;
                st_data_next = src_data_reg & mask;
                nsi_next     = si_step;
                ndi_next     = di_step;
            end
            OP_CMPS:
            begin
                fl_en_next = 1'b1;
                flags_next = sub_flags(src_data_reg, dst_data_reg, mask, top);
                nsi_next   = si_step;
                ndi_next   = di_step;
            end
            OP_SCAS:
            begin
                fl_en_next = 1'b1;
                flags_next = sub_flags(accumulator_reg, dst_data_reg, mask, top);
                ndi_next   = di_step;
            end
            OP_STOS:
            begin
                st_en_next   = 1'b1;
                st_data_next = accumulator_reg & mask;
                ndi_next     = di_step;
            end
            OP_LODS:
            begin
                acc_next = (accumulator_reg & ~mask) | (src_data_reg & mask);
                nsi_next = si_step;
            end
            default:
            begin
                // unused opcode: pass everything through
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nsi_reg     <= nsi_next;
            ndi_reg     <= ndi_next;
            seg_reg     <= seg_next;
            st_en_reg   <= st_en_next;
            st_data_reg <= st_data_next;
            acc_reg     <= acc_next;
            fl_en_reg   <= fl_en_next;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_src_index = nsi_reg;
    assign next_dst_index = ndi_reg;
    assign src_segment    = seg_reg;
    assign store_enable   = st_en_reg;
    assign store_data     = st_data_reg;
    assign acc_result     = acc_reg;
    assign flags_write    = fl_en_reg;
    assign flags_out      = flags_reg;

endmodule

`default_nettype wire

// ===== src/x86str_chk.sv =====
`default_nettype none

`include "x86_string_instruction_step_core_assert.svh"

module x86str_chk
    import x86str_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] next_src_index,
    input wire logic [31:0] next_dst_index,
    input wire logic [2:0]  src_segment,
    input wire logic        store_enable,
    input wire logic [31:0] store_data,
    input wire logic [31:0] acc_result,
    input wire logic        flags_write,
    input wire logic [5:0]  flags_out
);

    logic [138:0] result_bits;

    assign result_bits = {next_src_index, next_dst_index, src_segment, store_enable,
                          store_data, acc_result, flags_write, flags_out};

    // Hold a stalled result
    `X86STR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

    // Drop flags unless a compare wrote them
    `X86STR_ASSERT_NOW(a_flags_zero, out_valid && !flags_write, flags_out == 6'd0)

    // A store and a compare never come from one instruction
    `X86STR_ASSERT_NOW(a_store_excl, out_valid && store_enable, !flags_write)

    // Source segment is always a real segment, DS by default
    `X86STR_ASSERT_NOW(a_seg_range, out_valid, src_segment <= SEG_MAX)

    // With no store, the store data is zero
    `X86STR_ASSERT_NOW(a_store_zero, out_valid && !store_enable, store_data == 32'd0)

endmodule

bind x86_string_instruction_step_core x86str_chk u_x86str_chk (.*);

`default_nettype wire

// ===== bench/x86_string_instruction_step_core_test.sv =====
`default_nettype none

module x86_string_instruction_step_core_test;
    import x86str_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [2:0] OP_NONE_LO = 3'd5;
    localparam logic [2:0] OP_NONE_HI = 3'd7;
    localparam logic [1:0] SZ_ODD     = 2'd3;
    localparam logic [2:0] SEG_ES     = 3'd0;
    localparam logic [2:0] SEG_NONE   = 3'd6;
    localparam logic [2:0] SEG_ODD    = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  elem_size;
        logic        addr_32;
        logic        dir_down;
        logic [2:0]  seg_override;
        logic [31:0] src_index;
        logic [31:0] dst_index;
        logic [31:0] accumulator;
        logic [31:0] src_data;
        logic [31:0] dst_data;
    } string_step_t;

    typedef struct packed {
        logic [31:0] next_src_index;
        logic [31:0] next_dst_index;
        logic [2:0]  src_segment;
        logic        store_enable;
        logic [31:0] store_data;
        logic [31:0] acc_result;
        logic        flags_write;
        logic [5:0]  flags_out;
    } step_update_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [1:0]  elem_size;
    logic        addr_32;
    logic        dir_down;
    logic [2:0]  seg_override;
    logic [31:0] src_index;
    logic [31:0] dst_index;
    logic [31:0] accumulator;
    logic [31:0] src_data;
    logic [31:0] dst_data;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] next_src_index;
    logic [31:0] next_dst_index;
    logic [2:0]  src_segment;
    logic        store_enable;
    logic [31:0] store_data;
    logic [31:0] acc_result;
    logic        flags_write;
    logic [5:0]  flags_out;

    step_update_t awaited_updates[$];
    step_update_t oldest_update;
    int          failures;
    int unsigned cycle_count;
    bit          no_idle;

    x86_string_instruction_step_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .elem_size      (elem_size),
        .addr_32        (addr_32),
        .dir_down       (dir_down),
        .seg_override   (seg_override),
        .src_index      (src_index),
        .dst_index      (dst_index),
        .accumulator    (accumulator),
        .src_data       (src_data),
        .dst_data       (dst_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_src_index (next_src_index),
        .next_dst_index (next_dst_index),
        .src_segment    (src_segment),
        .store_enable   (store_enable),
        .store_data     (store_data),
        .acc_result     (acc_result),
        .flags_write    (flags_write),
        .flags_out      (flags_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] advance_index(logic [31:0] idx, logic [2:0] stride,
                                                  logic down, logic wide);
        logic [31:0] moved;
        moved = down ? idx - 32'(stride) : idx + 32'(stride);
        // 16-bit addressing: wrap within the low half, hold the upper half
        return wide ? moved : {idx[31:16], moved[15:0]};
    endfunction

    function automatic logic [5:0] compare_flags(logic [31:0] lhs, logic [31:0] rhs,
                                                 logic [31:0] mask, int msb);
        logic [31:0] diff;
        logic [5:0]  f;
        lhs  = lhs & mask;
        rhs  = rhs & mask;
        diff = (lhs - rhs) & mask;
        f[5] = (lhs[msb] != rhs[msb]) && (diff[msb] != lhs[msb]);
        f[4] = diff[msb];
        f[3] = (diff == 32'd0);
        f[2] = lhs[4] ^ rhs[4] ^ diff[4];
        f[1] = ~^diff[7:0];
        f[0] = (lhs < rhs);
        return f;
    endfunction

    function automatic step_update_t predict_string_step(string_step_t s);
        step_update_t u;
        logic [31:0]  mask;
        logic [2:0]   stride;
        int           msb;
        case (s.elem_size)
            SZ_BYTE:
            begin
                mask = 32'h0000_00FF; stride = 3'd1; msb = 7;
            end
            SZ_WORD:
            begin
                mask = 32'h0000_FFFF; stride = 3'd2; msb = 15;
            end
            default:
            begin
                mask = 32'hFFFF_FFFF; stride = 3'd4; msb = 31;
            end
        endcase
        u.next_src_index = s.src_index;
        u.next_dst_index = s.dst_index;
        u.src_segment    = (s.seg_override > SEG_MAX) ? SEG_DS : s.seg_override;
        u.store_enable   = 1'b0;
        u.store_data     = 32'd0;
        u.acc_result     = s.accumulator;
        u.flags_write    = 1'b0;
        u.flags_out      = 6'd0;
        case (s.opcode)
            OP_MOVS:
            begin
                u.store_enable   = 1'b1;
                u.store_data     = s.src_data & mask;
                u.next_src_index = advance_index(s.src_index, stride, s.dir_down, s.addr_32);
                u.next_dst_index = advance_index(s.dst_index, stride, s.dir_down, s.addr_32);
            end
            OP_CMPS:
            begin
                u.flags_write    = 1'b1;
                u.flags_out      = compare_flags(s.src_data, s.dst_data, mask, msb);
                u.next_src_index = advance_index(s.src_index, stride, s.dir_down, s.addr_32);
                u.next_dst_index = advance_index(s.dst_index, stride, s.dir_down, s.addr_32);
            end
            OP_SCAS:
            begin
                u.flags_write    = 1'b1;
                u.flags_out      = compare_flags(s.accumulator, s.dst_data, mask, msb);
                u.next_dst_index = advance_index(s.dst_index, stride, s.dir_down, s.addr_32);
            end
            OP_STOS:
            begin
                u.store_enable   = 1'b1;
                u.store_data     = s.accumulator & mask;
                u.next_dst_index = advance_index(s.dst_index, stride, s.dir_down, s.addr_32);
            end
            OP_LODS:
            begin
                u.acc_result     = (s.accumulator & ~mask) | (s.src_data & mask);
                u.next_src_index = advance_index(s.src_index, stride, s.dir_down, s.addr_32);
            end
            default:
            begin
            end
        endcase
        return u;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic string_step_t make_step(logic [2:0] op, logic [1:0] size,
                                               logic wide, logic down, logic [2:0] seg,
                                               logic [31:0] si, logic [31:0] di,
                                               logic [31:0] acc, logic [31:0] sd,
                                               logic [31:0] dd);
        string_step_t s;
        s.opcode       = op;
        s.elem_size    = size;
        s.addr_32      = wide;
        s.dir_down     = down;
        s.seg_override = seg;
        s.src_index    = si;
        s.dst_index    = di;
        s.accumulator  = acc;
        s.src_data     = sd;
        s.dst_data     = dd;
        return s;
    endfunction

    // Bias indexes towards the 16-bit and 32-bit wrap points.
    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {16'($urandom), 16'hFFFF - 16'($urandom_range(0, 3))};
            2: return {16'($urandom), 16'($urandom_range(0, 3))};
            default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 3))
                                                 : 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic string_step_t random_step();
        string_step_t s;
        logic [2:0]   op;
        logic [31:0]  dd;
        logic [31:0]  sd;
        logic [31:0]  acc;
        if ($urandom_range(0, 99) < 92)
            op = 3'($urandom_range(OP_MOVS, OP_LODS));
        else
            op = 3'($urandom_range(OP_NONE_LO, OP_NONE_HI));
        dd  = $urandom;
        // equal operands now and then so that the zero flag is reached
        sd  = ($urandom_range(0, 9) < 3) ? {16'($urandom), dd[15:0]} : $urandom;
        acc = ($urandom_range(0, 9) < 3) ? {24'($urandom), dd[7:0]} : $urandom;
        if ($urandom_range(0, 9) < 2)
            dd = sd;
        s = make_step(op, 2'($urandom_range(SZ_BYTE, SZ_ODD)), 1'($urandom),
                      1'($urandom), 3'($urandom_range(SEG_ES, SEG_ODD)),
                      pick_index(), pick_index(), acc, sd, dd);
        return s;
    endfunction

    // Present one step, hold it until the transfer, then leave valid up or idle.
    task automatic send_step(string_step_t s);
        int gap;
        in_valid     <= 1'b1;
        opcode       <= s.opcode;
        elem_size    <= s.elem_size;
        addr_32      <= s.addr_32;
        dir_down     <= s.dir_down;
        seg_override <= s.seg_override;
        src_index    <= s.src_index;
        dst_index    <= s.dst_index;
        accumulator  <= s.accumulator;
        src_data     <= s.src_data;
        dst_data     <= s.dst_data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        awaited_updates.push_back(predict_string_step(s));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------- result checking

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_updates.size() == 0)
            begin
                $error("result transfer with no step outstanding");
                failures++;
            end
            else
            begin
                oldest_update = awaited_updates.pop_front();
                compare_field("next_src_index", oldest_update.next_src_index, next_src_index);
                compare_field("next_dst_index", oldest_update.next_dst_index, next_dst_index);
                compare_field("src_segment", 32'(oldest_update.src_segment), 32'(src_segment));
                compare_field("store_enable", 32'(oldest_update.store_enable),
                              32'(store_enable));
                compare_field("store_data", oldest_update.store_data, store_data);
                compare_field("acc_result", oldest_update.acc_result, acc_result);
                compare_field("flags_write", 32'(oldest_update.flags_write), 32'(flags_write));
                compare_field("flags_out", 32'(oldest_update.flags_out), 32'(flags_out));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : result_stall
        int run;
        out_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run = pick_gap();
            if (run > 0)
            begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_each_operation();
        for (int op = OP_MOVS; op <= OP_NONE_HI; op++)
            send_step(make_step(3'(op), SZ_WORD, 1'b1, 1'b0, SEG_NONE, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
    endtask

    task automatic test_index_wrap();
        send_step(make_step(OP_MOVS, SZ_DWORD, 1'b0, 1'b0, SEG_ES, 32'h1234_FFFF,
                            32'hFFFF_FFFE, $urandom, $urandom, $urandom));
        send_step(make_step(OP_MOVS, SZ_BYTE, 1'b0, 1'b1, SEG_NONE, 32'hABCD_0000,
                            32'h0000_0000, $urandom, $urandom, $urandom));
        send_step(make_step(OP_CMPS, SZ_WORD, 1'b1, 1'b0, SEG_MAX, 32'hFFFF_FFFF,
                            32'hFFFF_FFFE, $urandom, $urandom, $urandom));
        send_step(make_step(OP_STOS, SZ_DWORD, 1'b1, 1'b1, SEG_DS, 32'h0000_0000,
                            32'h0000_0002, $urandom, $urandom, $urandom));
    endtask

    task automatic test_flag_cases();
        send_step(make_step(OP_CMPS, SZ_BYTE, 1'b1, 1'b0, SEG_NONE, $urandom, $urandom,
                            $urandom, 32'hFFFF_FF80, 32'h0000_0001));
        send_step(make_step(OP_CMPS, SZ_WORD, 1'b0, 1'b1, SEG_NONE, $urandom, $urandom,
                            $urandom, 32'h1234_0000, 32'h0000_0001));
        send_step(make_step(OP_SCAS, SZ_DWORD, 1'b1, 1'b0, SEG_NONE, $urandom, $urandom,
                            32'h7FFF_FFFF, $urandom, 32'hFFFF_FFFF));
        send_step(make_step(OP_CMPS, SZ_DWORD, 1'b1, 1'b1, SEG_NONE, $urandom, $urandom,
                            $urandom, 32'h8000_0000, 32'h8000_0000));
        send_step(make_step(OP_SCAS, SZ_BYTE, 1'b0, 1'b0, SEG_NONE, $urandom, $urandom,
                            32'hDEAD_BE10, $urandom, 32'h1234_5601));
        send_step(make_step(OP_LODS, SZ_WORD, 1'b0, 1'b0, SEG_NONE, $urandom, $urandom,
                            32'hFFFF_FFFF, 32'h0000_0000, $urandom));
        send_step(make_step(OP_STOS, SZ_BYTE, 1'b1, 1'b0, SEG_NONE, $urandom, $urandom,
                            32'hFFFF_FFFF, $urandom, $urandom));
    endtask

    task automatic test_odd_codes();
        // size code 3 acts as dword, segment code 7 as no override
        send_step(make_step(OP_MOVS, SZ_ODD, 1'b1, 1'b0, SEG_NONE, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
        send_step(make_step(OP_LODS, SZ_ODD, 1'b0, 1'b1, SEG_ODD, $urandom, $urandom,
                            $urandom, $urandom, $urandom));
        send_step(make_step(OP_MOVS, SZ_BYTE, 1'b0, 1'b0, SEG_ES, 32'd0, 32'd0, 32'd0,
                            32'd0, 32'd0));
        send_step(make_step(OP_NONE_HI, SZ_ODD, 1'b1, 1'b1, SEG_ODD, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_steps();
        repeat (1200) send_step(random_step());
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (200) send_step(random_step());
        no_idle = 1'b0;
    endtask

    initial
    begin
        failures     = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_MOVS;
        elem_size    <= SZ_BYTE;
        addr_32      <= 1'b0;
        dir_down     <= 1'b0;
        seg_override <= SEG_NONE;
        src_index    <= 32'd0;
        dst_index    <= 32'd0;
        accumulator  <= 32'd0;
        src_data     <= 32'd0;
        dst_data     <= 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_operation();
        test_index_wrap();
        test_flag_cases();
        test_odd_codes();
        test_random_steps();
        test_back_to_back();

        in_valid <= 1'b0;
        while (awaited_updates.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
